// File: rtl/mtcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtcd_pkg
// Types, codes and the magic table for the chunk deframer.
// ----------------------------------------------------------------------------
package mtcd_pkg;

    localparam int unsigned MAGIC_BYTES_DEF = 8;
    localparam logic [7:0]  ESC_BYTE        = 8'hFF;
    localparam logic [31:0] DESC_MIN_LEN    = 32'd3;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_ID      = 3'd1,
        PH_ID_ESC  = 3'd2,
        PH_LEN     = 3'd3,
        PH_LEN_ESC = 3'd4,
        PH_BODY    = 3'd5,
        PH_BAD     = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        K_HEADER   = 3'd0,
        K_BODY     = 3'd1,
        K_OK       = 3'd2,
        K_BADMAGIC = 3'd3,
        K_TRUNC    = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_payload;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] chunk_id;
        logic [31:0] chunk_length;
        logic [7:0]  body_byte;
        logic        last_of_chunk;
        logic        is_descriptor;
    } t_out_item;

    // Up to two results per byte; res1 is only valid alongside res0.
    typedef struct packed {
        logic      v0;
        logic      v1;
        t_out_item res0;
        t_out_item res1;
    } t_step_res;

    // "SBEM0103", then zeros for longer magic settings.
    function automatic logic [7:0] magic_byte(input logic [3:0] pos);
        logic [7:0] b;
        case (pos)
            4'd0:    b = 8'h53;
            4'd1:    b = 8'h42;
            4'd2:    b = 8'h45;
            4'd3:    b = 8'h4D;
            4'd4:    b = 8'h30;
            4'd5:    b = 8'h31;
            4'd6:    b = 8'h30;
            4'd7:    b = 8'h33;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/mtcd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtcd_parser
// Per-byte parse state and result generation, one byte per cycle while i_take is high.
// ----------------------------------------------------------------------------
module mtcd_parser #(
    parameter int unsigned MAGIC_BYTES = mtcd_pkg::MAGIC_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_take,
    input  wire mtcd_pkg::t_in_item i_item,
    output mtcd_pkg::t_step_res     o_res
);

    localparam logic [4:0] MagicLen = 5'(MAGIC_BYTES);

    mtcd_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_mpos, n_mpos;
    logic [1:0]       r_esc, n_esc;
    logic [31:0]      r_val, n_val;
    logic [31:0]      r_id, n_id;
    logic [31:0]      r_left, n_left;

    mtcd_pkg::t_out_item hdr, stat;
    logic                hdr_v;
    logic [7:0]          b;
    logic [4:0]          mpos_inc;

    always_comb begin
        b        = i_item.data_byte;
        mpos_inc = {1'b0, r_mpos} + 5'd1;
        n_phase  = r_phase;
        n_mpos   = r_mpos;
        n_esc    = r_esc;
        n_val    = r_val;
        n_id     = r_id;
        n_left   = r_left;
        hdr_v    = 1'b0;
        hdr      = '0;
        stat     = '0;

        case (r_phase)
            mtcd_pkg::PH_MAGIC: begin
                if (b == mtcd_pkg::magic_byte(r_mpos)) begin
                    n_mpos = mpos_inc[3:0];
                    if (mpos_inc >= MagicLen) begin
                        n_phase = mtcd_pkg::PH_ID;
                    end
                end else begin
                    n_phase = mtcd_pkg::PH_BAD;
                end
            end
            mtcd_pkg::PH_ID, mtcd_pkg::PH_LEN: begin
                if (b == mtcd_pkg::ESC_BYTE) begin
                    n_esc   = 2'd0;
                    n_val   = '0;
                    n_phase = (r_phase == mtcd_pkg::PH_ID) ? mtcd_pkg::PH_ID_ESC
                                                           : mtcd_pkg::PH_LEN_ESC;
                end else if (r_phase == mtcd_pkg::PH_ID) begin
                    n_id    = {24'd0, b};
                    n_phase = mtcd_pkg::PH_LEN;
                end else begin
                    n_val = {24'd0, b};
                    hdr_v = 1'b1;
                end
            end
            mtcd_pkg::PH_ID_ESC, mtcd_pkg::PH_LEN_ESC: begin
                // little-endian assembly, one byte lane per escape byte
                n_val = r_val | ({24'd0, b} << {r_esc, 3'b000});
                n_esc = r_esc + 2'd1;
                if (r_esc == 2'd3) begin
                    if (r_phase == mtcd_pkg::PH_ID_ESC) begin
                        n_id    = n_val;
                        n_val   = '0;
                        n_phase = mtcd_pkg::PH_LEN;
                    end else begin
                        hdr_v = 1'b1;
                    end
                end
            end
            mtcd_pkg::PH_BODY: begin
                n_left            = r_left - 32'd1;
                hdr_v             = 1'b1;
                hdr.kind          = mtcd_pkg::K_BODY;
                hdr.chunk_id      = r_id;
                hdr.chunk_length  = r_val;
                hdr.body_byte     = b;
                hdr.last_of_chunk = (n_left == '0);
                hdr.is_descriptor = (r_id == '0) && (r_val >= mtcd_pkg::DESC_MIN_LEN);
                if (n_left == '0) begin
                    n_phase = mtcd_pkg::PH_ID;
                end
            end
            default: begin
                n_phase = mtcd_pkg::PH_BAD;
            end
        endcase

        // header complete: length now sits in n_val
        if (hdr_v && r_phase != mtcd_pkg::PH_BODY) begin
            hdr.kind          = mtcd_pkg::K_HEADER;
            hdr.chunk_id      = n_id;
            hdr.chunk_length  = n_val;
            hdr.is_descriptor = (n_id == '0) && (n_val >= mtcd_pkg::DESC_MIN_LEN);
            n_left            = n_val;
            n_phase           = (n_val == '0) ? mtcd_pkg::PH_ID : mtcd_pkg::PH_BODY;
        end

        if (n_phase == mtcd_pkg::PH_ID) begin
            stat.kind = mtcd_pkg::K_OK;
        end else if (n_phase == mtcd_pkg::PH_MAGIC || n_phase == mtcd_pkg::PH_BAD) begin
            stat.kind = mtcd_pkg::K_BADMAGIC;
        end else begin
            stat.kind = mtcd_pkg::K_TRUNC;
        end

        if (i_item.end_of_payload) begin
            n_phase = mtcd_pkg::PH_MAGIC;
            n_mpos  = '0;
            n_esc   = '0;
            n_val   = '0;
            n_id    = '0;
            n_left  = '0;
        end

        o_res.v0   = hdr_v | i_item.end_of_payload;
        o_res.v1   = hdr_v & i_item.end_of_payload;
        o_res.res0 = hdr_v ? hdr : stat;
        o_res.res1 = stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mtcd_pkg::PH_MAGIC;
            r_mpos  <= '0;
            r_esc   <= '0;
            r_val   <= '0;
            r_id    <= '0;
            r_left  <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_mpos  <= n_mpos;
            r_esc   <= n_esc;
            r_val   <= n_val;
            r_id    <= n_id;
            r_left  <= n_left;
        end
    end

endmodule
`default_nettype wire

// File: rtl/magic_tlv_chunk_deframer_core.sv
// A result enters the result queue when its byte is taken and is offered on
// o_out once earlier results have left. Throughput: one byte per cycle while
// each byte gives at most one result and the sink takes one result per cycle;
// a closing byte's header or body result and status leave in turn by one port.
// Reset (i_rst_n low, synchronous) returns the parser to the magic check and
// empties the result queue.
`default_nettype none
// ----------------------------------------------------------------------------
// magic_tlv_chunk_deframer_core
// Byte-serial deframer: magic check, escaped id/length chunk headers, body
// pass-through and an end-of-payload status, behind a small result queue.
// ----------------------------------------------------------------------------
module magic_tlv_chunk_deframer_core #(
    parameter int unsigned MAGIC_BYTES = mtcd_pkg::MAGIC_BYTES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // byte input
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire mtcd_pkg::t_in_item  i_in,
    // result output
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output mtcd_pkg::t_out_item      o_out
);

    // Four-entry result queue. A byte is taken only with room for two
    // results, so the parser never has to stall mid-byte.
    localparam int unsigned QDepth = 4;
    localparam int unsigned PtrW   = $clog2(QDepth);

    mtcd_pkg::t_out_item r_q [QDepth];
    logic [PtrW-1:0]     r_wr, r_rd;
    logic [PtrW:0]       r_cnt, n_cnt;

    mtcd_pkg::t_step_res step;
    logic                in_take, out_take;
    logic [PtrW-1:0]     wr1;
    logic [PtrW:0]       n_push;

    assign o_in_ready  = (r_cnt <= (PtrW+1)'(QDepth - 2));
    assign in_take     = i_in_valid & o_in_ready;
    assign o_out_valid = (r_cnt != '0);
    assign out_take    = o_out_valid & i_out_ready;
    assign o_out       = r_q[r_rd];

    mtcd_parser #(
        .MAGIC_BYTES (MAGIC_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_take),
        .i_item  (i_in),
        .o_res   (step)
    );

    always_comb begin
        wr1    = r_wr + PtrW'(1);
        n_push = in_take ? ((PtrW+1)'(step.v0) + (PtrW+1)'(step.v1)) : '0;
        n_cnt  = r_cnt + n_push - (PtrW+1)'(out_take);
    end

    // queue payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take && step.v0) begin
            r_q[r_wr] <= step.res0;
        end
        if (in_take && step.v1) begin
            r_q[wr1] <= step.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + n_push[PtrW-1:0];
            r_rd  <= r_rd + PtrW'(out_take);
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire
